@@ rtl/fvfs_pkg.sv @@
package fvfs_pkg;

   // Node table geometry and field widths
   localparam int NODE_COUNT = 1024;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int NODE_W     = 10;
   localparam int KIND_W     = 3;
   localparam int VAL_W      = 3;
   localparam int PIV_W      = 2;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_FAULT_NODE  = 1'b0;
   localparam logic CSR_IDX_STUCK_VALUE = 1'b1;

   typedef logic [VAL_W-1:0] val_type;

   // Five-valued codes
   localparam val_type V_ZERO = 3'd0;
   localparam val_type V_ONE  = 3'd1;
   localparam val_type V_X    = 3'd2;
   localparam val_type V_D    = 3'd3;
   localparam val_type V_DB   = 3'd4;

   localparam logic [PIV_W-1:0] PIV_X = 2'd2;
   localparam logic [PIV_W-1:0] PIV_UNUSED = 2'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_INPUT  = 3'd0,
      KIND_BUFFER = 3'd1,
      KIND_NOT    = 3'd2,
      KIND_AND    = 3'd3,
      KIND_NAND   = 3'd4,
      KIND_OR     = 3'd5,
      KIND_NOR    = 3'd6
   } gate_kind_type;

   // Write request into the node value table
   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      val_type            data;
   } table_wr_type;

   localparam val_type AND_TAB [0:4][0:4] = '{
      '{V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO},
      '{V_ZERO, V_ONE,  V_X,    V_D,    V_DB  },
      '{V_ZERO, V_X,    V_X,    V_X,    V_X   },
      '{V_ZERO, V_D,    V_X,    V_D,    V_ZERO},
      '{V_ZERO, V_DB,   V_X,    V_ZERO, V_DB  }
   };

   localparam val_type OR_TAB [0:4][0:4] = '{
      '{V_ZERO, V_ONE,  V_X,    V_D,    V_DB  },
      '{V_ONE,  V_ONE,  V_ONE,  V_ONE,  V_ONE },
      '{V_X,    V_ONE,  V_X,    V_X,    V_X   },
      '{V_D,    V_ONE,  V_X,    V_D,    V_ONE },
      '{V_DB,   V_ONE,  V_X,    V_ONE,  V_DB  }
   };

   localparam val_type INV_TAB [0:4] = '{V_ONE, V_ZERO, V_X, V_DB, V_D};

   // Map codes above Db to X
   function automatic val_type clamp_val(input val_type v);
      return (v > V_DB) ? V_X : v;
   endfunction

   function automatic val_type and_val(input val_type a, input val_type b);
      return AND_TAB[clamp_val(a)][clamp_val(b)];
   endfunction

   function automatic val_type or_val(input val_type a, input val_type b);
      return OR_TAB[clamp_val(a)][clamp_val(b)];
   endfunction

   function automatic val_type inv_val(input val_type a);
      return INV_TAB[clamp_val(a)];
   endfunction

endpackage

@@ rtl/five_valued_fault_simulator.sv @@
// Channel | Direction | Word contents
// req_    | in        | tdata: node, fanin, first_fanin, pi_value, is_output; tuser: gate_kind;
//         |           | tlast: last_fanin
// rsp_    | out       | tdata: out_node, value, detected (one per last_fanin of a known kind)
// csr_    | in/out    | reg 0 fault_node at 0x0, reg 1 stuck_value at 0x4
//
// Two stages: the accept edge issues the node table read at the fanin and loads
// stage two, which folds the read value and writes the node back on its last fanin.
// One word per cycle sustained while rsp_ is not stalled; the table's single write/read
// port pair sets it, and a write that collides with the following read is forwarded.
// A stalled rsp_ output register holds stage two only for a word marked last_fanin.
// Reset is synchronous; the node table is not cleared and must be written before read.
module five_valued_fault_simulator
   import fvfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // node [9:0], fanin [19:10], first_fanin [20], pi_value [22:21], is_output [23]
   input  logic [23:0]       req_tdata,
   // gate_kind [2:0]
   input  logic [2:0]        req_tuser,
   input  logic              req_tlast,
   input  logic              req_tvalid,
   output logic              req_tready,
   // out_node [9:0], value [12:10], detected [13], zero [15:14]
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Configuration registers
   logic [NODE_W-1:0] fault_node_ff;
   logic              stuck_value_ff;
   logic              csr_write;

   // Stage two registers
   logic              s1_valid_ff;
   logic [NODE_W-1:0] s1_node_ff;
   logic [KIND_W-1:0] s1_kind_ff;
   logic              s1_first_ff;
   logic              s1_last_ff;
   logic [PIV_W-1:0]  s1_piv_ff;
   logic              s1_is_out_ff;

   logic              req_accept;
   logic              out_free;
   logic              proc;
   logic              kind_ok;
   logic              rsp_load;

   val_type           fold_value_ff;
   val_type           fold_value_in;
   val_type           res;
   val_type           tbl_value;
   table_wr_type      tbl_wr;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff;
   val_type           rsp_value_ff;
   logic              rsp_detected_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_node_ff  <= '0;
         stuck_value_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_IDX_FAULT_NODE:  fault_node_ff  <= csr_pwdata[NODE_W-1:0];
            CSR_IDX_STUCK_VALUE: stuck_value_ff <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_FAULT_NODE:  csr_prdata = {{(CSR_DW-NODE_W){1'b0}}, fault_node_ff};
         CSR_IDX_STUCK_VALUE: csr_prdata = {{(CSR_DW-1){1'b0}}, stuck_value_ff};
      endcase
   end

   // Flow control: stage two moves unless its result has nowhere to go
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || proc;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_node_ff   <= req_tdata[9:0];
         s1_kind_ff   <= req_tuser;
         s1_first_ff  <= req_tdata[20];
         s1_last_ff   <= req_tlast;
         s1_piv_ff    <= req_tdata[22:21];
         s1_is_out_ff <= req_tdata[23];
      end
   end

   fvfs_value_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_tdata[10 +: NODE_AW]),
      .wr       (tbl_wr),
      .rd_value (tbl_value)
   );

   // Fold the fanin value and finish the node on its last fanin
   always_comb begin
      fold_value_in = clamp_val(fold_value_ff);
      kind_ok       = 1'b1;
      unique case (s1_kind_ff)
         KIND_INPUT: begin
            fold_value_in = (s1_piv_ff == PIV_UNUSED) ? V_X : val_type'(s1_piv_ff);
         end
         KIND_BUFFER: begin
            if (s1_first_ff) fold_value_in = clamp_val(tbl_value);
         end
         KIND_NOT: begin
            if (s1_first_ff) fold_value_in = inv_val(tbl_value);
         end
         KIND_AND, KIND_NAND: begin
            fold_value_in = and_val(s1_first_ff ? V_ONE : fold_value_ff, tbl_value);
         end
         KIND_OR, KIND_NOR: begin
            fold_value_in = or_val(s1_first_ff ? V_ZERO : fold_value_ff, tbl_value);
         end
         default: begin
            kind_ok = 1'b0;
         end
      endcase

      res = fold_value_in;
      if ((s1_kind_ff == KIND_NAND) || (s1_kind_ff == KIND_NOR)) begin
         res = inv_val(fold_value_in);
      end
      if (s1_node_ff == fault_node_ff) begin
         if (!stuck_value_ff && (res == V_ONE)) begin
            res = V_D;
         end else if (stuck_value_ff && (res == V_ZERO)) begin
            res = V_DB;
         end
      end
   end

   assign rsp_load    = proc && kind_ok && s1_last_ff;
   assign tbl_wr.en   = rsp_load;
   assign tbl_wr.addr = s1_node_ff[NODE_AW-1:0];
   assign tbl_wr.data = res;

   // Advance the running fold
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_value_ff <= V_ZERO;
      end else if (proc && kind_ok) begin
         fold_value_ff <= fold_value_in;
      end
   end

   // Output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_node_ff     <= s1_node_ff;
         rsp_value_ff    <= res;
         rsp_detected_ff <= s1_is_out_ff && ((res == V_D) || (res == V_DB));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_detected_ff, rsp_value_ff, rsp_node_ff};

   // Detection only on a D or Db value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_detected_ff) |-> ((rsp_value_ff == V_D) || (rsp_value_ff == V_DB)))
      else $error("detected flag without D or Db");

   // A result is never loaded over a word still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over a pending word");

   // The running fold stays within the legal codes
   assert property (@(posedge clock) disable iff (reset)
      fold_value_ff <= V_DB)
      else $error("fold value code out of range");

   // A loaded result appears on the port in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

@@ rtl/fvfs_value_table.sv @@
module fvfs_value_table
   import fvfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [NODE_AW-1:0] rd_addr,
   input  table_wr_type       wr,
   output val_type            rd_value
);

   val_type            mem [NODE_COUNT];
   val_type            rd_data_ff;
   logic [NODE_AW-1:0] rd_addr_ff;
   logic               fwd_valid_ff;
   logic [NODE_AW-1:0] fwd_addr_ff;
   val_type            fwd_data_ff;

   // Write port and registered read port (read returns the old entry)
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Capture the write that lands on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_valid_ff <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   // Forward the colliding write over the stale read data
   assign rd_value = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : rd_data_ff;

   // A forwarded entry always carries a legal code
   assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> (fwd_data_ff <= V_DB))
      else $error("forwarded value code out of range");

endmodule

@@ test/testbench.sv @@
module testbench;
   import fvfs_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int PHASE_ITEMS  = 110;
   localparam int SETTLE       = 8;
   localparam int TIMEOUT      = 600000;
   localparam int SHOWN_ERRORS = 10;

   localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd7;
   localparam logic [CSR_AW-1:0] ADDR_FAULT_NODE  = {CSR_IDX_FAULT_NODE, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_STUCK_VALUE = {CSR_IDX_STUCK_VALUE, 2'b00};

   // One fanin word of a gate
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] fanin;
      logic              first_fanin;
      logic              last_fanin;
      logic [PIV_W-1:0]  pi_value;
      logic              is_output;
   } gate_word_type;

   // Laid out as in rsp_tdata, node in the low bits
   typedef struct packed {
      logic              detected;
      val_type           value;
      logic [NODE_W-1:0] node;
   } node_result_type;

   typedef enum logic {ROW_GATE, ROW_FAULT} row_kind_type;

   typedef struct {
      row_kind_type    what;
      gate_word_type   word;
      bit              pinned;
      node_result_type result;
   } plan_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic [23:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = '0;
   logic              req_tlast   = 1'b0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [15:0]       rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   five_valued_fault_simulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Shadow of the block: node table, running fold and fault setting
   val_type           node_val [NODE_COUNT];
   bit                written [NODE_COUNT];
   logic [NODE_W-1:0] written_list [$];
   val_type           fold_now = V_ZERO;
   logic [NODE_W-1:0] fault_at = '0;
   logic              fault_pol = 1'b0;

   node_result_type   pending_nodes [$];
   int                errors = 0;
   int                gate_items = 0;
   bit                tx_calm = 1'b0;
   bit                rx_calm = 1'b0;
   int                rsp_stall = 0;

   // Split a code into {fault-free, faulty} machine bits; X never gets here
   function automatic logic [1:0] split_machines(input val_type v);
      case (v)
         V_ONE:   return 2'b11;
         V_D:     return 2'b10;
         V_DB:    return 2'b01;
         default: return 2'b00;
      endcase
   endfunction

   function automatic val_type join_machines(input logic [1:0] gf);
      case (gf)
         2'b11:   return V_ONE;
         2'b10:   return V_D;
         2'b01:   return V_DB;
         default: return V_ZERO;
      endcase
   endfunction

   // A controlling value wins over X; otherwise both machines are evaluated apart
   function automatic val_type d_and(input val_type a, input val_type b);
      if (a == V_ZERO || b == V_ZERO) return V_ZERO;
      if (a == V_X || b == V_X) return V_X;
      return join_machines(split_machines(a) & split_machines(b));
   endfunction

   function automatic val_type d_or(input val_type a, input val_type b);
      if (a == V_ONE || b == V_ONE) return V_ONE;
      if (a == V_X || b == V_X) return V_X;
      return join_machines(split_machines(a) | split_machines(b));
   endfunction

   function automatic val_type d_not(input val_type a);
      if (a == V_X) return V_X;
      return join_machines(~split_machines(a));
   endfunction

   // Fold one word of a known kind into the shadow; return 1 with the node result on its last fanin
   function automatic bit evaluate_gate(input gate_word_type w, output node_result_type r);
      val_type v;
      val_type acc;
      r = '0;
      if (w.kind == KIND_IGNORED) return 1'b0;
      v = node_val[w.fanin];
      acc = fold_now;
      case (w.kind)
         KIND_INPUT:          acc = (w.pi_value == PIV_UNUSED) ? V_X : val_type'(w.pi_value);
         KIND_BUFFER:         if (w.first_fanin) acc = v;
         KIND_NOT:            if (w.first_fanin) acc = d_not(v);
         KIND_AND, KIND_NAND: acc = d_and(w.first_fanin ? V_ONE : acc, v);
         default:             acc = d_or(w.first_fanin ? V_ZERO : acc, v);
      endcase
      fold_now = acc;
      if (!w.last_fanin) return 1'b0;
      if (w.kind == KIND_NAND || w.kind == KIND_NOR) acc = d_not(acc);
      // Inject the stuck-at fault; X, D and Db pass unchanged
      if (w.node == fault_at) begin
         if (!fault_pol && acc == V_ONE) acc = V_D;
         else if (fault_pol && acc == V_ZERO) acc = V_DB;
      end
      node_val[w.node] = acc;
      if (!written[w.node]) begin
         written[w.node] = 1'b1;
         written_list.push_back(w.node);
      end
      r.node = w.node;
      r.value = acc;
      r.detected = w.is_output && (acc == V_D || acc == V_DB);
      return 1'b1;
   endfunction

   task automatic flag(input string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("%s", msg);
   endtask

   // Prefer recently written nodes so fault effects travel down the netlist
   function automatic logic [NODE_W-1:0] pick_fanin();
      int n;
      n = written_list.size();
      if (n == 0) return NODE_W'($urandom_range(0, NODE_COUNT - 1));
      if ($urandom_range(0, 1)) return written_list[$urandom_range(n - 1, (n > 16) ? n - 16 : 0)];
      return written_list[$urandom_range(0, n - 1)];
   endfunction

   function automatic plan_row_type gate_row(input int node, input logic [KIND_W-1:0] kind,
                                             input int fanin, input bit head, input bit tail,
                                             input logic [PIV_W-1:0] piv, input bit is_out,
                                             input bit pinned, input val_type value,
                                             input bit detected);
      plan_row_type r;
      r.what = ROW_GATE;
      r.word = '{node: NODE_W'(node), kind: kind, fanin: NODE_W'(fanin), first_fanin: head,
                 last_fanin: tail, pi_value: piv, is_output: is_out};
      r.pinned = pinned;
      r.result = '{detected: detected, value: value, node: NODE_W'(node)};
      return r;
   endfunction

   function automatic plan_row_type fault_row(input int node, input bit stuck);
      plan_row_type r;
      r = gate_row(node, KIND_INPUT, 0, 1'b0, 1'b0, '0, stuck, 1'b0, V_ZERO, 1'b0);
      r.what = ROW_FAULT;
      return r;
   endfunction

   // Offer one word after a random gap and record what it should produce
   task automatic send_word(input gate_word_type w, input bit pinned,
                            input node_result_type pin_res);
      int gap;
      node_result_type res;
      gap = tx_calm ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {w.is_output, w.pi_value, w.first_fanin, w.fanin, w.node};
      req_tuser <= w.kind;
      req_tlast <= w.last_fanin;
      do @(posedge clock); while (!req_tready);
      if (evaluate_gate(w, res)) pending_nodes.push_back(pinned ? pin_res : res);
   endtask

   // Hold off until every result is back and the pipeline has emptied
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_nodes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One APB transfer; psel stays high so transfers can run back to back
   task automatic csr_cycle(input bit wr, input logic [CSR_AW-1:0] addr,
                            input logic [CSR_DW-1:0] data, output logic [CSR_DW-1:0] rd);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
   endtask

   task automatic set_fault(input logic [NODE_W-1:0] at, input logic stuck);
      logic [CSR_DW-1:0] rd;
      csr_cycle(1'b1, ADDR_FAULT_NODE, CSR_DW'(at), rd);
      fault_at = at;
      csr_cycle(1'b1, ADDR_STUCK_VALUE, CSR_DW'(stuck), rd);
      fault_pol = stuck;
      csr_cycle(1'b0, ADDR_FAULT_NODE, '0, rd);
      if (rd != CSR_DW'(at))
         flag($sformatf("fault_node read %0d, expected %0d", rd, at));
      csr_cycle(1'b0, ADDR_STUCK_VALUE, '0, rd);
      if (rd != CSR_DW'(stuck))
         flag($sformatf("stuck_value read %0d, expected %0d", rd, stuck));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One gate as a run of fanin words; a tenth get scrambled first/last marks
   task automatic send_random_gate();
      gate_word_type w;
      int n_items;
      bit noise;
      w.node = ($urandom_range(0, 7) == 0) ? fault_at : NODE_W'($urandom_range(0, NODE_COUNT - 1));
      w.kind = ($urandom_range(0, 19) == 0) ? KIND_IGNORED
                                            : KIND_W'($urandom_range(KIND_INPUT, KIND_NOR));
      w.is_output = 1'($urandom_range(0, 1));
      if (w.kind == KIND_IGNORED) n_items = 1;
      else if (w.kind >= KIND_AND) n_items = $urandom_range(1, 5);
      else n_items = $urandom_range(1, 3);
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n_items; i++) begin
         w.fanin = pick_fanin();
         w.pi_value = PIV_W'($urandom_range(0, 3));
         w.first_fanin = noise ? 1'($urandom_range(0, 1)) : (i == 0);
         w.last_fanin = noise ? 1'($urandom_range(0, 1)) : (i == n_items - 1);
         send_word(w, 1'b0, '0);
         if (w.kind != KIND_IGNORED) gate_items++;
      end
   endtask

   // Check each result word against the oldest pending node; stall at random
   always @(posedge clock) begin : rsp_side
      node_result_type got;
      node_result_type want;
      int stall_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[13:0];
         if (pending_nodes.size() == 0) begin
            flag($sformatf("unexpected word: node %0d value %0d detected %0d",
                           got.node, got.value, got.detected));
         end else begin
            want = pending_nodes.pop_front();
            if (got !== want)
               flag($sformatf("node %0d value %0d det %0d, expected node %0d value %0d det %0d",
                              got.node, got.value, got.detected,
                              want.node, want.value, want.detected));
         end
         stall_n = rx_calm ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
         rsp_tready <= (stall_n == 0);
         rsp_stall <= stall_n;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      plan_row_type plan [$];
      int phase;
      int phase_start;

      // Directed netlist; the fault starts on node 0, stuck-at-0
      plan.push_back(gate_row(0,    KIND_INPUT,   0,    1, 1, 1,          1, 1, V_D,    1));
      plan.push_back(gate_row(1023, KIND_INPUT,   0,    1, 1, 0,          1, 1, V_ZERO, 0));
      plan.push_back(gate_row(1,    KIND_INPUT,   1023, 1, 1, PIV_X,      0, 1, V_X,    0));
      plan.push_back(gate_row(2,    KIND_INPUT,   0,    1, 1, PIV_UNUSED, 1, 1, V_X,    0));
      plan.push_back(gate_row(3,    KIND_INPUT,   1,    1, 0, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(3,    KIND_INPUT,   2,    0, 1, 1,          0, 1, V_ONE,  0));
      plan.push_back(gate_row(4,    KIND_BUFFER,  0,    1, 1, 0,          1, 1, V_D,    1));
      plan.push_back(gate_row(5,    KIND_NOT,     1023, 1, 1, 0,          0, 1, V_ONE,  0));
      plan.push_back(gate_row(6,    KIND_BUFFER,  3,    1, 0, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(6,    KIND_BUFFER,  1023, 0, 1, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(7,    KIND_AND,     0,    1, 0, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(7,    KIND_AND,     3,    0, 1, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(8,    KIND_NAND,    0,    1, 0, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(8,    KIND_NAND,    4,    0, 1, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(9,    KIND_OR,      1023, 1, 0, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(9,    KIND_OR,      1,    0, 1, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(10,   KIND_NOR,     1023, 1, 0, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(10,   KIND_NOR,     0,    0, 1, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(11,   KIND_IGNORED, 0,    1, 1, 3,          1, 0, V_ZERO, 0));
      // Gates not marked first fold into whatever the previous node left
      plan.push_back(gate_row(12,   KIND_AND,     5,    0, 1, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(13,   KIND_OR,      1,    0, 1, 0,          0, 0, V_ZERO, 0));
      plan.push_back(gate_row(14,   KIND_NOT,     0,    1, 0, 0,          1, 0, V_ZERO, 0));
      plan.push_back(gate_row(14,   KIND_NOT,     1023, 0, 1, 0,          1, 0, V_ZERO, 0));
      plan.push_back(fault_row(1023, 1));
      plan.push_back(gate_row(1023, KIND_INPUT,   5,    1, 1, 0,          1, 1, V_DB,   1));
      plan.push_back(fault_row(20, 0));
      plan.push_back(gate_row(20,   KIND_NOT,     0,    1, 1, 0,          1, 1, V_DB,   1));
      plan.push_back(gate_row(20,   KIND_INPUT,   0,    1, 1, 1,          1, 1, V_D,    1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].what == ROW_FAULT) begin
            drain();
            set_fault(plan[i].word.node, plan[i].word.is_output);
         end else begin
            send_word(plan[i].word, plan[i].pinned, plan[i].result);
         end
      end

      // Random netlists, moving the fault between phases
      phase = 0;
      while (gate_items < RANDOM_ITEMS) begin
         drain();
         case (phase % 4)
            0:       set_fault('0, 1'b0);
            1:       set_fault(NODE_W'(NODE_COUNT - 1), 1'b1);
            default: set_fault(written_list[$urandom_range(0, written_list.size() - 1)],
                               1'($urandom_range(0, 1)));
         endcase
         phase_start = gate_items;
         while (gate_items - phase_start < PHASE_ITEMS && gate_items < RANDOM_ITEMS)
            send_random_gate();
         phase++;
      end
      drain();

      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("testbench: done, errors");
      $finish;
   end

endmodule
